@@ design/ddo_pkg.sv @@
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the wheel odometry block
// Item codes, queue entry, result record, sequencer states, CORDIC table.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  // input kind codes
  localparam logic [2:0] KIND_LEFT   = 3'd0;
  localparam logic [2:0] KIND_RIGHT  = 3'd1;
  localparam logic [2:0] KIND_UPDATE = 3'd2;
  localparam logic [2:0] KIND_SET    = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_MPT  = 2'd0;
  localparam logic [1:0] CFG_APMD = 2'd1;

  localparam logic [31:0] MPT_RESET  = 32'd2147484;
  localparam logic [39:0] APMD_RESET = 40'd4557000000;

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] QUARTER  = 34'sd1073741824;
  localparam logic signed [33:0] HALF     = 34'sd2147483648;
  localparam logic [19:0]        MICRO    = 20'd1000000;

  // divider geometry: 84-bit dividend, 4 quotient bits per cycle
  localparam int NUM_W     = 84;
  localparam int DEN_W     = 22;
  localparam int DIGIT_W   = 4;
  localparam int DIV_STEPS = NUM_W / DIGIT_W;

  typedef enum logic [2:0] {
    OP_NONE, OP_LEFT, OP_RIGHT, OP_UPDATE, OP_SET, OP_CLEAR
  } op_code_t;

  typedef struct packed {
    op_code_t    op;
    logic [21:0] period;
    logic [31:0] new_heading;
  } op_t;

  typedef struct packed {
    logic push;
    op_t  item;
  } q_req_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic [31:0] linear_speed;
    logic [47:0] turn_rate;
    logic [31:0] left_count;
    logic [31:0] right_count;
    logic        pose_updated;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_DIFF, ST_ANG_LO, ST_ANG_HI, ST_PREP, ST_LIN,
    ST_RATE, ST_ITER, ST_MOVE_X, ST_MOVE_Y, ST_FIN
  } back_state_t;

  function automatic logic [29:0] atan_of(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'd536870912;
      5'd1:  a = 30'd316933406;
      5'd2:  a = 30'd167458907;
      5'd3:  a = 30'd85004756;
      5'd4:  a = 30'd42667331;
      5'd5:  a = 30'd21354465;
      5'd6:  a = 30'd10679838;
      5'd7:  a = 30'd5340245;
      5'd8:  a = 30'd2670163;
      5'd9:  a = 30'd1335087;
      5'd10: a = 30'd667544;
      5'd11: a = 30'd333772;
      5'd12: a = 30'd166886;
      5'd13: a = 30'd83443;
      5'd14: a = 30'd41722;
      5'd15: a = 30'd20861;
      5'd16: a = 30'd10430;
      5'd17: a = 30'd5215;
      5'd18: a = 30'd2608;
      5'd19: a = 30'd1304;
      5'd20: a = 30'd652;
      5'd21: a = 30'd326;
      5'd22: a = 30'd163;
      5'd23: a = 30'd81;
      5'd24: a = 30'd41;
      5'd25: a = 30'd20;
      5'd26: a = 30'd10;
      5'd27: a = 30'd5;
      5'd28: a = 30'd3;
      5'd29: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  // saturate a 37-bit signed sum to 32 bits
  function automatic logic [31:0] sat32(input logic [36:0] v);
    logic [31:0] r;
    if (!v[36] && (|v[35:31])) begin
      r = 32'h7FFF_FFFF;
    end else if (v[36] && !(&v[35:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/ddo_if.sv @@
// ----------------------------------------------------------------------------
// ddo_if: item and result channels
// Valid/ready channels carrying the input item and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddo_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [21:0] period_us;
  logic [31:0] new_heading;
  modport source(output valid, kind, period_us, new_heading, input ready);
  modport sink(input valid, kind, period_us, new_heading, output ready);
endinterface

interface ddo_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] heading;
  logic [31:0] linear_speed;
  logic [47:0] turn_rate;
  logic [31:0] left_count;
  logic [31:0] right_count;
  logic        pose_updated;
  modport source(output valid, pos_x, pos_y, heading, linear_speed, turn_rate,
                 left_count, right_count, pose_updated, input ready);
  modport sink(input valid, pos_x, pos_y, heading, linear_speed, turn_rate,
               left_count, right_count, pose_updated, output ready);
endinterface

`default_nettype wire

@@ design/differential_drive_odometry_top.sv @@
// ----------------------------------------------------------------------------
// differential_drive_odometry_top: differential-drive wheel odometry
// Encoder tick counting and midpoint pose integration with CORDIC and
// iterative rate division.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      contents
//  in_ch     in   valid/ready    kind, period_us, new_heading
//  out_ch    out  valid/ready    pose, speeds, counters, pose_updated
//  cfg       in   cfg_we         cfg_index, cfg_data (no read-back)
//
//  Edge, set-heading, clear and no-op items are applied when popped in idle.
//  An update holds the back end through the tick products, heading change,
//  CORDIC iterations, 4-bit-per-cycle rate dividers and position move.
//  A two-entry queue lets intake continue while an update is running.
//  Reset is synchronous; clears odometry and control state, loads cfg defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  ddo_in_if.sink      in_ch,
  ddo_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data
);

  ddo_pkg::q_req_t  q_req;
  ddo_pkg::op_t     q_item;
  ddo_pkg::result_t res;
  logic             q_full, q_valid, q_pop;

  ddo_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_req  (q_req)
  );

  ddo_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_req   (q_req),
    .pop     (q_pop),
    .full    (q_full),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  ddo_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (out_ch.valid),
    .res       (res),
    .res_ready (out_ch.ready)
  );

  assign out_ch.pos_x        = res.pos_x;
  assign out_ch.pos_y        = res.pos_y;
  assign out_ch.heading      = res.heading;
  assign out_ch.linear_speed = res.linear_speed;
  assign out_ch.turn_rate    = res.turn_rate;
  assign out_ch.left_count   = res.left_count;
  assign out_ch.right_count  = res.right_count;
  assign out_ch.pose_updated = res.pose_updated;

endmodule

`default_nettype wire

@@ design/ddo_front.sv @@
// ----------------------------------------------------------------------------
// ddo_front: item intake
// Takes input items and turns the kind code into a queue operation.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_front (
  ddo_in_if.sink          in_ch,
  input  logic            q_full,
  output ddo_pkg::q_req_t q_req
);

  ddo_pkg::op_code_t op;

  always_comb begin
    case (in_ch.kind)
      ddo_pkg::KIND_LEFT:   op = ddo_pkg::OP_LEFT;
      ddo_pkg::KIND_RIGHT:  op = ddo_pkg::OP_RIGHT;
      // an update over a zero period is a no-op
      ddo_pkg::KIND_UPDATE: op = (in_ch.period_us == 22'd0) ? ddo_pkg::OP_NONE
                                                            : ddo_pkg::OP_UPDATE;
      ddo_pkg::KIND_SET:    op = ddo_pkg::OP_SET;
      ddo_pkg::KIND_CLEAR:  op = ddo_pkg::OP_CLEAR;
      default:              op = ddo_pkg::OP_NONE;
    endcase
  end

  assign in_ch.ready            = !q_full;
  assign q_req.push             = in_ch.valid && !q_full;
  assign q_req.item.op          = op;
  assign q_req.item.period      = in_ch.period_us;
  assign q_req.item.new_heading = in_ch.new_heading;

endmodule

`default_nettype wire

@@ design/ddo_queue.sv @@
// ----------------------------------------------------------------------------
// ddo_queue: two-entry operation queue
// Decouples intake from execution.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_queue (
  input  logic            clk,
  input  logic            rst,
  input  ddo_pkg::q_req_t q_req,
  input  logic            pop,
  output logic            full,
  output logic            q_valid,
  output ddo_pkg::op_t    q_item
);

  ddo_pkg::op_t slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_req.push) begin
      slots[wr_ptr] <= q_req.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_req.push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({q_req.push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/ddo_div.sv @@
// ----------------------------------------------------------------------------
// ddo_div: radix-16 restoring divider
// Unsigned 84-bit by 22-bit, four quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ddo_pkg::NUM_W-1:0]   num,
  input  logic [ddo_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [ddo_pkg::NUM_W-1:0]   quot
);

  localparam int CNT_W = $clog2(ddo_pkg::DIV_STEPS + 1);

  logic [ddo_pkg::NUM_W-1:0] acc;
  logic [ddo_pkg::DEN_W-1:0] rem;
  logic [ddo_pkg::DEN_W-1:0] dvs;
  logic [CNT_W-1:0]          cnt;

  logic [ddo_pkg::NUM_W-1:0] acc_next;
  logic [ddo_pkg::DEN_W-1:0] rem_next;
  logic [ddo_pkg::DEN_W:0]   trial;

  // acc shifts the dividend out at the top and the quotient in at the bottom
  always_comb begin
    acc_next = acc;
    rem_next = rem;
    trial    = '0;
    for (int k = 0; k < ddo_pkg::DIGIT_W; k++) begin
      trial    = {rem_next, acc_next[ddo_pkg::NUM_W-1]};
      acc_next = {acc_next[ddo_pkg::NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_next    = ddo_pkg::DEN_W'(trial - {1'b0, dvs});
        acc_next[0] = 1'b1;
      end else begin
        rem_next = trial[ddo_pkg::DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= num;
      rem <= '0;
      dvs <= den;
    end else if (cnt != '0) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(ddo_pkg::DIV_STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  assign done = (cnt == '0);
  assign quot = acc;

endmodule

`default_nettype wire

@@ design/ddo_back.sv @@
// ----------------------------------------------------------------------------
// ddo_back: execution engine
// Holds the odometry state and runs the update sequence: tick products,
// heading change, CORDIC of the mid heading, two rate dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [39:0]             cfg_data,
  input  logic                    q_valid,
  input  ddo_pkg::op_t            q_item,
  output logic                    q_pop,
  output logic                    res_valid,
  output ddo_pkg::result_t        res,
  input  logic                    res_ready
);

  localparam int STEP_W = $clog2(CORDIC_STEPS + 1);

  ddo_pkg::back_state_t state, state_next;

  // configuration
  logic [31:0] mpt;
  logic [39:0] apmd;

  // architectural state
  logic [31:0] left_ticks, right_ticks, left_seen, right_seen;
  logic [31:0] x_pos, y_pos, head, lin_vel;
  logic [47:0] ang_vel;
  logic [31:0] left_next, right_next, left_seen_next, right_seen_next;
  logic [31:0] x_next, y_next, head_next, lin_next;
  logic [47:0] ang_vel_next;

  // update working registers
  logic         sneg, tneg;
  logic [32:0]  smag, tmag;
  logic [21:0]  period;
  logic [64:0]  sprod;
  logic [31:0]  dd;
  logic [63:0]  pprod;
  logic [71:0]  acc_lo;
  logic [103:0] ang;
  logic [51:0]  ang_part;
  logic [51:0]  lin_num;
  logic         flip;
  logic signed [33:0] cx, cy, cz;
  logic [STEP_W-1:0]  ccnt;

  logic out_free, take_simple, load_out, div_start;

  // deltas since the last update
  logic [31:0] dl, dr;
  logic [32:0] sum, dif;
  assign dl  = left_ticks - left_seen;
  assign dr  = right_ticks - right_seen;
  assign sum = {dr[31], dr} + {dl[31], dl};
  assign dif = {dr[31], dr} - {dl[31], dl};

  // centre travel, saturated
  logic [47:0] ddmag;
  logic [31:0] dd_sat, dd_abs;
  assign ddmag = sprod[64:17];
  always_comb begin
    if (sneg) begin
      dd_sat = (ddmag > 48'h8000_0000) ? 32'h8000_0000 : -ddmag[31:0];
    end else begin
      dd_sat = (ddmag > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : ddmag[31:0];
    end
  end
  assign dd_abs = dd[31] ? -dd : dd;

  // heading change and its half
  logic [31:0] dth, half, mid;
  logic        ang_hi;
  logic [63:0] vmag;
  assign dth    = tneg ? -ang[63:32] : ang[63:32];
  assign half   = tneg ? -ang[64:33] : ang[64:33];
  assign mid    = head + half;
  assign ang_hi = |ang[103:96];
  assign vmag   = ang_hi ? '1 : ang[95:32];

  logic [ddo_pkg::NUM_W-1:0] ang_num;
  assign ang_num = {52'(vmag[63:32]) * 52'(ddo_pkg::MICRO), 32'd0}
                 + ddo_pkg::NUM_W'(ang_part);

  // fold the mid heading by pi into [-pi/2, pi/2]
  logic signed [33:0] mz;
  assign mz = $signed({{2{mid[31]}}, mid});

  // CORDIC rotation step
  logic signed [33:0] xs, ys, at;
  assign xs = cx >>> ccnt;
  assign ys = cy >>> ccnt;
  assign at = $signed({4'd0, ddo_pkg::atan_of(5'(ccnt))});

  // position move: one shared multiplier for x and y
  logic signed [33:0] cs_val, sn_val, mul_b;
  logic signed [65:0] mprod;
  logic [35:0]        term;
  logic [31:0]        base;
  logic [36:0]        moved;
  assign cs_val = flip ? -cx : cx;
  assign sn_val = flip ? -cy : cy;
  assign mul_b  = (state == ddo_pkg::ST_MOVE_X) ? cs_val : sn_val;
  assign mprod  = $signed(dd) * mul_b;
  assign term   = mprod[65:30];
  assign base   = (state == ddo_pkg::ST_MOVE_X) ? x_pos : y_pos;
  assign moved  = {{5{base[31]}}, base} + {term[35], term};

  // rate dividers
  logic                      lin_done, ang_done;
  logic [ddo_pkg::NUM_W-1:0] lin_q, ang_q;

  ddo_div u_div_lin (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (ddo_pkg::NUM_W'(lin_num)),
    .den   (period),
    .done  (lin_done),
    .quot  (lin_q)
  );

  ddo_div u_div_ang (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (ang_num),
    .den   (period),
    .done  (ang_done),
    .quot  (ang_q)
  );

  logic [31:0] lin_lim, lin_mag;
  logic [47:0] ang_lim, ang_mag;
  assign lin_lim = dd[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign lin_mag = ((|lin_q[83:32]) || (lin_q[31:0] > lin_lim)) ? lin_lim : lin_q[31:0];
  assign ang_lim = tneg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
  assign ang_mag = ((|ang_q[83:48]) || (ang_q[47:0] > ang_lim)) ? ang_lim : ang_q[47:0];

  // sequencer
  assign out_free = !res_valid || res_ready;

  always_comb begin
    state_next = state;
    case (state)
      ddo_pkg::ST_IDLE: begin
        if (q_valid && out_free && (q_item.op == ddo_pkg::OP_UPDATE)) begin
          state_next = ddo_pkg::ST_SUM;
        end
      end
      ddo_pkg::ST_SUM:    state_next = ddo_pkg::ST_DIFF;
      ddo_pkg::ST_DIFF:   state_next = ddo_pkg::ST_ANG_LO;
      ddo_pkg::ST_ANG_LO: state_next = ddo_pkg::ST_ANG_HI;
      ddo_pkg::ST_ANG_HI: state_next = ddo_pkg::ST_PREP;
      ddo_pkg::ST_PREP:   state_next = ddo_pkg::ST_LIN;
      ddo_pkg::ST_LIN:    state_next = ddo_pkg::ST_RATE;
      ddo_pkg::ST_RATE:   state_next = ddo_pkg::ST_ITER;
      ddo_pkg::ST_ITER: begin
        if ((ccnt == STEP_W'(CORDIC_STEPS)) && lin_done && ang_done) begin
          state_next = ddo_pkg::ST_MOVE_X;
        end
      end
      ddo_pkg::ST_MOVE_X: state_next = ddo_pkg::ST_MOVE_Y;
      ddo_pkg::ST_MOVE_Y: state_next = ddo_pkg::ST_FIN;
      ddo_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = ddo_pkg::ST_IDLE;
        end
      end
      default: state_next = ddo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = (state == ddo_pkg::ST_IDLE) && q_valid && out_free;
    take_simple = q_pop && (q_item.op != ddo_pkg::OP_UPDATE);
    load_out    = take_simple || ((state == ddo_pkg::ST_FIN) && out_free);
    div_start   = (state == ddo_pkg::ST_RATE);
  end

  // next architectural state
  always_comb begin
    left_next       = left_ticks;
    right_next      = right_ticks;
    left_seen_next  = left_seen;
    right_seen_next = right_seen;
    x_next          = x_pos;
    y_next          = y_pos;
    head_next       = head;
    lin_next        = lin_vel;
    ang_vel_next    = ang_vel;
    if (take_simple) begin
      case (q_item.op)
        ddo_pkg::OP_LEFT:  left_next  = left_ticks + 32'd1;
        ddo_pkg::OP_RIGHT: right_next = right_ticks + 32'd1;
        ddo_pkg::OP_SET:   head_next  = q_item.new_heading;
        ddo_pkg::OP_CLEAR: begin
          left_next       = '0;
          right_next      = '0;
          left_seen_next  = '0;
          right_seen_next = '0;
          x_next          = '0;
          y_next          = '0;
          head_next       = '0;
          lin_next        = '0;
          ang_vel_next    = '0;
        end
        default: ;
      endcase
    end
    if (state == ddo_pkg::ST_MOVE_X) begin
      x_next = ddo_pkg::sat32(moved);
    end
    if (state == ddo_pkg::ST_MOVE_Y) begin
      y_next          = ddo_pkg::sat32(moved);
      head_next       = head + dth;
      lin_next        = dd[31] ? -lin_mag : lin_mag;
      ang_vel_next    = tneg ? -ang_mag : ang_mag;
      left_seen_next  = left_ticks;
      right_seen_next = right_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ddo_pkg::ST_IDLE;
      mpt        <= ddo_pkg::MPT_RESET;
      apmd       <= ddo_pkg::APMD_RESET;
      left_ticks <= '0;
      right_ticks <= '0;
      left_seen  <= '0;
      right_seen <= '0;
      x_pos      <= '0;
      y_pos      <= '0;
      head       <= '0;
      lin_vel    <= '0;
      ang_vel    <= '0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && (cfg_index == ddo_pkg::CFG_MPT)) begin
        mpt <= cfg_data[31:0];
      end
      if (cfg_we && (cfg_index == ddo_pkg::CFG_APMD)) begin
        apmd <= cfg_data;
      end
      left_ticks  <= left_next;
      right_ticks <= right_next;
      left_seen   <= left_seen_next;
      right_seen  <= right_seen_next;
      x_pos       <= x_next;
      y_pos       <= y_next;
      head        <= head_next;
      lin_vel     <= lin_next;
      ang_vel     <= ang_vel_next;
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // update datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sneg   <= sum[32];
      tneg   <= dif[32];
      smag   <= sum[32] ? -sum : sum;
      tmag   <= dif[32] ? -dif : dif;
      period <= q_item.period;
    end
    case (state)
      ddo_pkg::ST_SUM:    sprod  <= 65'(smag) * 65'(mpt);
      ddo_pkg::ST_DIFF: begin
        dd    <= dd_sat;
        pprod <= 64'(tmag * 65'(mpt));
      end
      ddo_pkg::ST_ANG_LO: acc_lo <= pprod[31:0] * apmd;
      ddo_pkg::ST_ANG_HI: ang    <= {72'(pprod[63:32]) * 72'(apmd), 32'd0} + 104'(acc_lo);
      ddo_pkg::ST_PREP: begin
        ang_part <= vmag[31:0] * ddo_pkg::MICRO;
        cx       <= ddo_pkg::GAIN_Q30;
        cy       <= '0;
        ccnt     <= '0;
        if (mz > ddo_pkg::QUARTER) begin
          cz   <= mz - ddo_pkg::HALF;
          flip <= 1'b1;
        end else if (mz < -ddo_pkg::QUARTER) begin
          cz   <= mz + ddo_pkg::HALF;
          flip <= 1'b1;
        end else begin
          cz   <= mz;
          flip <= 1'b0;
        end
      end
      ddo_pkg::ST_LIN:    lin_num <= dd_abs * ddo_pkg::MICRO;
      ddo_pkg::ST_ITER: begin
        if (ccnt != STEP_W'(CORDIC_STEPS)) begin
          if (!cz[33]) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - at;
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + at;
          end
          ccnt <= ccnt + 1'b1;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      res.pos_x        <= x_next;
      res.pos_y        <= y_next;
      res.heading      <= head_next;
      res.linear_speed <= lin_next;
      res.turn_rate    <= ang_vel_next;
      res.left_count   <= left_next;
      res.right_count  <= right_next;
      res.pose_updated <= (state == ddo_pkg::ST_FIN);
    end
  end

endmodule

`default_nettype wire

@@ design/ddo_checker.sv @@
// ----------------------------------------------------------------------------
// ddo_checker: port-level checks
// Reset behaviour and result channel stability.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pos_x,
  input logic [31:0] heading,
  input logic [31:0] left_count,
  input logic        pose_updated
);

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_reset_in: assert property (@(posedge clk) $past(rst) |-> in_ready)
    else $error("intake not ready after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pos_x) && $stable(heading)
                                && $stable(left_count) && $stable(pose_updated))
    else $error("stalled result changed");

endmodule

bind differential_drive_odometry_top ddo_checker u_ddo_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pos_x        (out_ch.pos_x),
  .heading      (out_ch.heading),
  .left_count   (out_ch.left_count),
  .pose_updated (out_ch.pose_updated)
);

`default_nettype wire
